@@ design/fcte_pkg.sv @@
// ----------------------------------------------------------------------------
// fcte_pkg
// Shared types and constants for the file allocation table chain engine:
// table geometry, operation and status codes, request and response beats.
// ----------------------------------------------------------------------------
package fcte_pkg;

  // table geometry
  localparam int NUM_BLOCKS = 4096;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int COUNT_W    = 13;

  localparam logic [15:0]        CHAIN_END   = 16'hFFFF;
  localparam logic [15:0]        NUM_BLK16   = 16'(NUM_BLOCKS);
  localparam logic [COUNT_W-1:0] NUM_CNT     = COUNT_W'(NUM_BLOCKS);
  localparam logic [COUNT_W-1:0] USABLE_RST  = COUNT_W'(4096);

  // operation codes
  localparam logic [2:0] OP_NEW    = 3'd0;
  localparam logic [2:0] OP_EXTEND = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_COUNT  = 3'd3;
  localparam logic [2:0] OP_SKIP   = 3'd4;
  localparam logic [2:0] OP_WRITE  = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_LOOP = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [15:0]        start_block;
    logic [COUNT_W-1:0] amount;
    logic [15:0]        raw_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        result_block;
    logic [COUNT_W-1:0] result_count;
    logic [1:0]         status;
  } out_item_t;

endpackage

@@ design/fat_chain_table_engine.sv @@
// ----------------------------------------------------------------------------
// fat_chain_table_engine
// 16-bit file allocation table with chain operations, built around one
// single-port-write, registered-read table memory and a sequencer.
// ----------------------------------------------------------------------------
// usage
//   request beats arrive on in_valid/in_ready with an in_item_t payload, one
//   response beat per request leaves on out_valid/out_ready as out_item_t
//   the usable block count is written through cfg_we/cfg_wdata while idle
//   after rst the table memory is cleared one entry a cycle: in_ready stays
//   low until all NUM_BLOCKS (4096) entries are cleared, config writes are taken meanwhile
// steps per request through the one table read port (one access per cycle)
//   raw write, bad or empty start, unused op: straight to the response
//   raw read: one table read
//   new chain: scan from entry 0, mark the entry found; full: scan to the limit
//   count, skip: a read and a check per link followed, stopped by an end
//   mark, a bad link, the skip amount or the loop limit
//   free chain: a read and a clear per entry
//   extend: walk to the chain end as above, then per new block a scan from
//   entry 0, a link write and an end mark write
// one request is in work at a time; the response sits in an output
// register, so the next request is taken while a response waits; a stalled
// receiver holds the sequencer in its final state until the slot frees
// ----------------------------------------------------------------------------
module fat_chain_table_engine
  import fcte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_item
);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_SCAN    = 11'b000_0000_0100,
    S_WALK_RD = 11'b000_0000_1000,
    S_WALK_CK = 11'b000_0001_0000,
    S_LINK    = 11'b000_0010_0000,
    S_MARK    = 11'b000_0100_0000,
    S_FREE_RD = 11'b000_1000_0000,
    S_FREE_CK = 11'b001_0000_0000,
    S_READ    = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

  state_t state;

  // config
  logic [COUNT_W-1:0] usable_block_count;

  // request context
  logic [2:0]         op_q;
  logic [COUNT_W-1:0] amt_q;

  // work registers
  logic [ADDR_W-1:0]  cur;        // walk cursor / chain end / clear address
  logic [ADDR_W-1:0]  fidx;       // free entry found by the scan
  logic [COUNT_W-1:0] cnt;        // links taken or blocks handled
  logic [COUNT_W-1:0] scan_addr;  // next address issued by the scan
  logic [COUNT_W-1:0] chk;        // address whose data is in rd_data
  logic               pend;       // rd_data holds a scan read
  logic [15:0]        res_block;
  logic [1:0]         status;

  // table memory
  logic [15:0]        fat_mem [NUM_BLOCKS];
  logic [15:0]        rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [15:0]        mem_wd;
  logic [ADDR_W-1:0]  mem_ra;

  logic in_fire;
  logic sb_empty;
  logic sb_inr;
  logic nxt_end;
  logic nxt_bad;
  logic scan_fail;
  logic scan_hit;
  logic walk_end;
  logic [1:0] walk_st;
  logic [COUNT_W-1:0] cnt_inc;

  // request decode
  state_t      dec_state;
  logic [1:0]  dec_status;
  logic [15:0] dec_block;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign sb_empty = (in_item.start_block == CHAIN_END);
  assign sb_inr   = (in_item.start_block < NUM_BLK16);
  assign cnt_inc  = cnt + COUNT_W'(1);

  // link just read from the table
  assign nxt_end = (rd_data == CHAIN_END);
  assign nxt_bad = !nxt_end && (rd_data >= NUM_BLK16);

  // free scan: rd_data belongs to chk; stop at the usable limit or the table end
  assign scan_fail = pend && ((chk >= usable_block_count) || (chk == NUM_CNT));
  assign scan_hit  = pend && !scan_fail && (rd_data == 16'd0);

  // first state, status and result block of an accepted request
  always_comb begin
    dec_state  = S_DONE;
    dec_status = ST_OK;
    dec_block  = 16'd0;
    case (in_item.op)
      OP_NEW: begin
        dec_state = S_SCAN;
      end
      OP_EXTEND: begin
        if (sb_empty) begin
          dec_block  = CHAIN_END;
          dec_status = ST_BAD;
        end else if (!sb_inr) begin
          dec_status = ST_BAD;
        end else begin
          dec_state = S_WALK_RD;
        end
      end
      OP_FREE: begin
        if (!sb_empty && !sb_inr) begin
          dec_status = ST_BAD;
        end else if (!sb_empty) begin
          dec_state = S_FREE_RD;
        end
      end
      OP_COUNT: begin
        if (!sb_empty && !sb_inr) begin
          dec_status = ST_BAD;
        end else if (!sb_empty) begin
          dec_state = S_WALK_RD;
        end
      end
      OP_SKIP: begin
        if (sb_empty) begin
          dec_block = CHAIN_END;
        end else if (!sb_inr) begin
          dec_status = ST_BAD;
        end else begin
          dec_state = S_WALK_RD;
        end
      end
      OP_WRITE: begin
        if (!sb_inr) begin
          dec_status = ST_BAD;
        end else begin
          dec_block = in_item.raw_value;
        end
      end
      OP_READ: begin
        if (!sb_inr) begin
          dec_status = ST_BAD;
        end else begin
          dec_state = S_READ;
        end
      end
      default: begin
        dec_state = S_DONE;
      end
    endcase
  end

  // walk stop conditions, before and after the table read
  always_comb begin
    walk_end = 1'b0;
    walk_st  = ST_OK;
    case (state)
      S_WALK_RD: begin
        if (cnt == NUM_CNT) begin
          walk_end = 1'b1;
          walk_st  = ST_LOOP;
        end else if (op_q == OP_SKIP && cnt == amt_q) begin
          walk_end = 1'b1;
        end
      end
      S_WALK_CK: begin
        if (nxt_end) begin
          walk_end = 1'b1;
        end else if (nxt_bad) begin
          walk_end = 1'b1;
          walk_st  = ST_BAD;
        end
      end
      default: begin
        walk_end = 1'b0;
      end
    endcase
  end

  // table port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur;
    mem_wd = 16'd0;
    mem_ra = cur;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_ra = in_item.start_block[ADDR_W-1:0];
        if (in_fire && in_item.op == OP_WRITE && sb_inr) begin
          mem_we = 1'b1;
          mem_wa = in_item.start_block[ADDR_W-1:0];
          mem_wd = in_item.raw_value;
        end
      end
      S_SCAN: begin
        mem_ra = scan_addr[ADDR_W-1:0];
      end
      S_LINK: begin
        mem_we = 1'b1;
        mem_wd = 16'(fidx);
      end
      S_MARK: begin
        mem_we = 1'b1;
        mem_wa = fidx;
        mem_wd = CHAIN_END;
      end
      S_FREE_CK: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fat_mem[mem_wa] <= mem_wd;
    end
    rd_data <= fat_mem[mem_ra];
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      usable_block_count <= USABLE_RST;
    end else if (cfg_we) begin
      usable_block_count <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cur       <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // the final state reloads the slot itself when it frees
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cur <= cur + ADDR_W'(1);
          if (cur == ADDR_W'(NUM_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            op_q      <= in_item.op;
            amt_q     <= in_item.amount;
            cur       <= in_item.start_block[ADDR_W-1:0];
            cnt       <= '0;
            status    <= dec_status;
            res_block <= dec_block;
            scan_addr <= '0;
            pend      <= 1'b0;
            state     <= dec_state;
          end
        end

        S_READ: begin
          res_block <= rd_data;
          state     <= S_DONE;
        end

        S_SCAN: begin
          if (scan_fail) begin
            status    <= ST_FULL;
            res_block <= (op_q == OP_NEW) ? CHAIN_END : 16'(cur);
            pend      <= 1'b0;
            state     <= S_DONE;
          end else if (scan_hit) begin
            fidx  <= chk[ADDR_W-1:0];
            pend  <= 1'b0;
            state <= (op_q == OP_NEW) ? S_MARK : S_LINK;
          end else begin
            chk       <= scan_addr;
            scan_addr <= scan_addr + COUNT_W'(1);
            pend      <= 1'b1;
          end
        end

        S_LINK: begin
          state <= S_MARK;
        end

        S_MARK: begin
          cur <= fidx;
          cnt <= cnt_inc;
          if (op_q == OP_EXTEND && cnt_inc < amt_q) begin
            scan_addr <= '0;
            state     <= S_SCAN;
          end else begin
            res_block <= 16'(fidx);
            state     <= S_DONE;
          end
        end

        S_WALK_RD, S_WALK_CK: begin
          if (walk_end) begin
            res_block <= 16'(cur);
            status    <= walk_st;
            state     <= (op_q == OP_EXTEND && walk_st == ST_OK && amt_q != '0) ?
                         S_SCAN : S_DONE;
            case (op_q)
              OP_COUNT: begin
                cnt <= cnt_inc;
              end
              OP_EXTEND: begin
                cnt       <= '0;
                scan_addr <= '0;
              end
              default: begin
                cnt <= cnt;
              end
            endcase
          end else if (state == S_WALK_RD) begin
            state <= S_WALK_CK;
          end else begin
            cur   <= rd_data[ADDR_W-1:0];
            cnt   <= cnt_inc;
            state <= S_WALK_RD;
          end
        end

        S_FREE_RD: begin
          if (cnt == NUM_CNT) begin
            status <= ST_LOOP;
            state  <= S_DONE;
          end else begin
            state <= S_FREE_CK;
          end
        end

        S_FREE_CK: begin
          // entry at cur is cleared by the table port this cycle
          cnt <= cnt_inc;
          if (nxt_end) begin
            state <= S_DONE;
          end else if (nxt_bad) begin
            status <= ST_BAD;
            state  <= S_DONE;
          end else begin
            cur   <= rd_data[ADDR_W-1:0];
            state <= S_FREE_RD;
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_item.result_block <= res_block;
            out_item.result_count <= cnt;
            out_item.status       <= status;
            state                 <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // every accepted request leaves idle
  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != S_IDLE)
    else $error("accepted request did not start work");

  // link counters stay within the loop limit while reading links
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_CK || state == S_FREE_CK) |-> cnt < NUM_CNT)
    else $error("link count past loop limit");

  // an allocated entry always lies below the usable limit
  a_fidx_usable: assert property (@(posedge clk) disable iff (rst)
    state == S_MARK |-> COUNT_W'(fidx) < usable_block_count)
    else $error("allocated entry beyond usable block count");

  // a successful new chain hands out exactly one block
  a_new_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && op_q == OP_NEW && status == ST_OK) |-> cnt == COUNT_W'(1))
    else $error("new chain count is not one");

  // a response beat is only loaded from the final state
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> $past(state) == S_DONE)
    else $error("response loaded outside final state");

endmodule

@@ verif/fat_chain_table_engine_test.sv @@
// ----------------------------------------------------------------------------
// fat_chain_table_engine_test
// Self-checking bench for the chain table engine. Directed tasks cover chain
// creation, extension, walks, raw entries, broken chains and scan limits,
// then random traffic runs over several usable block counts. An in-bench
// copy of the table predicts every response beat, and a checker compares
// each beat field by field, in order, under random sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_test;
  import fcte_pkg::*;

  // op 7 has no function in the block
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;

  // bench copy of the table and the usable count
  logic [15:0]        fat_model [NUM_BLOCKS];
  logic [COUNT_W-1:0] usable_model;

  out_item_t          resp_expect_q [$];
  logic [15:0]        chain_heads [$];
  out_item_t          resp_want;
  int                 err_count;
  int                 tx_burst_left;

  fat_chain_table_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("Verification failed");
    $finish;
  end

  // lowest free entry below the usable limit
  function automatic bit fat_find_free(output int unsigned idx);
    int unsigned lim;
    lim = (usable_model < NUM_BLOCKS) ? usable_model : NUM_BLOCKS;
    idx = 0;
    for (int unsigned i = 0; i < lim; i++) begin
      if (fat_model[i] == 16'h0000) begin
        idx = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // follow up to want links, stop on end mark, bad link or loop limit
  function automatic logic [1:0] fat_walk(input int unsigned start, input int unsigned want,
                                          output int unsigned last, output int unsigned links);
    int unsigned cur;
    int unsigned n;
    int unsigned nxt;
    cur = start;
    n   = 0;
    while (1) begin
      if (n >= NUM_BLOCKS) begin
        last  = cur;
        links = n;
        return ST_LOOP;
      end
      if (n == want) break;
      nxt = fat_model[cur];
      if (nxt == CHAIN_END) break;
      if (nxt >= NUM_BLOCKS) begin
        last  = cur;
        links = n;
        return ST_BAD;
      end
      cur = nxt;
      n++;
    end
    last  = cur;
    links = n;
    return ST_OK;
  endfunction

  // applies one request to the bench table and returns the response beat
  function automatic out_item_t fat_apply_op(input in_item_t req);
    int unsigned rb;
    int unsigned rc;
    int unsigned idx;
    int unsigned last;
    int unsigned links;
    int unsigned cur;
    int unsigned nxt;
    logic [1:0]  st;
    bit          empty;
    bit          in_range;
    out_item_t   resp;
    rb       = 0;
    rc       = 0;
    st       = ST_OK;
    empty    = (req.start_block == CHAIN_END);
    in_range = (req.start_block < NUM_BLK16);
    case (req.op)
      OP_NEW: begin
        if (fat_find_free(idx)) begin
          fat_model[idx] = CHAIN_END;
          rb = idx;
          rc = 1;
        end else begin
          rb = CHAIN_END;
          st = ST_FULL;
        end
      end
      OP_EXTEND: begin
        if (empty) begin
          rb = CHAIN_END;
          st = ST_BAD;
        end else if (!in_range) begin
          st = ST_BAD;
        end else begin
          st = fat_walk(req.start_block, 32'hFFFF_FFFF, last, links);
          rb = last;
          if (st == ST_OK) begin
            // link one block at a time until the amount is linked or the scan comes up empty
            while (rc < req.amount && st == ST_OK) begin
              if (fat_find_free(idx)) begin
                fat_model[last] = 16'(idx);
                fat_model[idx]  = CHAIN_END;
                last = idx;
                rc++;
              end else begin
                st = ST_FULL;
              end
            end
            rb = last;
          end
        end
      end
      OP_FREE: begin
        if (!empty) begin
          if (!in_range) begin
            st = ST_BAD;
          end else begin
            cur = req.start_block;
            while (1) begin
              if (rc >= NUM_BLOCKS) begin
                st = ST_LOOP;
                break;
              end
              nxt = fat_model[cur];
              fat_model[cur] = 16'h0000;
              rc++;
              if (nxt == CHAIN_END) break;
              if (nxt >= NUM_BLOCKS) begin
                st = ST_BAD;
                break;
              end
              cur = nxt;
            end
          end
        end
      end
      OP_COUNT: begin
        if (!empty) begin
          if (!in_range) begin
            st = ST_BAD;
          end else begin
            st = fat_walk(req.start_block, 32'hFFFF_FFFF, last, links);
            rb = last;
            rc = links + 1;
          end
        end
      end
      OP_SKIP: begin
        if (empty) begin
          rb = CHAIN_END;
        end else if (!in_range) begin
          st = ST_BAD;
        end else begin
          st = fat_walk(req.start_block, req.amount, last, links);
          rb = last;
          rc = links;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          st = ST_BAD;
        end else begin
          fat_model[req.start_block] = req.raw_value;
          rb = req.raw_value;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          st = ST_BAD;
        end else begin
          rb = fat_model[req.start_block];
        end
      end
      default: begin
      end
    endcase
    resp.result_block = 16'(rb);
    resp.result_count = (rc > {COUNT_W{1'b1}}) ? {COUNT_W{1'b1}} : COUNT_W'(rc);
    resp.status       = st;
    return resp;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_count++;
    if (err_count <= 50) begin
      $display("mismatch %s: got %0h want %0h", what, got, want);
    end
  endtask

  // one request beat; valid is held until the beat is taken
  task automatic send_req(input logic [2:0] op, input logic [15:0] sb,
                          input logic [COUNT_W-1:0] amt, input logic [15:0] ev);
    in_item_t  req;
    out_item_t resp;
    int        gap;
    req.op          = op;
    req.start_block = sb;
    req.amount      = amt;
    req.raw_value   = ev;
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
    resp = fat_apply_op(req);
    resp_expect_q.push_back(resp);
    if (op == OP_NEW && resp.status == ST_OK) begin
      chain_heads.push_back(resp.result_block);
      if (chain_heads.size() > 32) chain_heads.delete(0);
    end
    // bursts of random length, random gaps between them
    if (tx_burst_left > 0) tx_burst_left--;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait until every predicted beat has come back, then let the block settle
  task automatic drain_responses();
    in_valid <= 1'b0;
    do @(posedge clk); while (resp_expect_q.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_usable_count(input logic [COUNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    usable_model = value;
    @(posedge clk);
  endtask

  task automatic test_new_chains();
    send_req(OP_NEW, 16'h0000, NUM_CNT, 16'h0000);
    send_req(OP_NEW, CHAIN_END, '0, 16'hFFFF);
  endtask

  task automatic test_extend_chain();
    send_req(OP_EXTEND, 16'h0000, COUNT_W'(3), 16'h0000);
    // empty chain is refused
    send_req(OP_EXTEND, CHAIN_END, COUNT_W'(5), 16'h0000);
    send_req(OP_EXTEND, NUM_BLK16, COUNT_W'(1), 16'h0000);
  endtask

  task automatic test_walk_chain();
    send_req(OP_COUNT, 16'h0000, '0, 16'h0000);
    send_req(OP_SKIP, 16'h0000, '0, 16'h0000);
    // chain shorter than the skip distance
    send_req(OP_SKIP, 16'h0000, NUM_CNT, 16'h0000);
    send_req(OP_SKIP, CHAIN_END, COUNT_W'(2), 16'h0000);
    send_req(OP_COUNT, CHAIN_END, '0, 16'h0000);
    send_req(OP_FREE, CHAIN_END, '0, 16'h0000);
  endtask

  task automatic test_raw_entries();
    send_req(OP_WRITE, 16'(NUM_BLOCKS - 1), '0, CHAIN_END);
    send_req(OP_READ, 16'(NUM_BLOCKS - 1), '0, 16'h0000);
    send_req(OP_WRITE, CHAIN_END, '0, 16'h1234);
  endtask

  task automatic test_broken_chains();
    // link pointing past the table
    send_req(OP_WRITE, 16'd100, '0, 16'h1234);
    send_req(OP_COUNT, 16'd100, '0, 16'h0000);
    // two-entry cycle
    send_req(OP_WRITE, 16'd200, '0, 16'd201);
    send_req(OP_WRITE, 16'd201, '0, 16'd200);
    send_req(OP_COUNT, 16'd200, '0, 16'h0000);
    send_req(OP_SKIP, 16'd200, NUM_CNT, 16'h0000);
    send_req(OP_EXTEND, 16'd200, COUNT_W'(1), 16'h0000);
    // clearing chain 0 first lets the cycle fall into free entry 0 until the loop limit
    send_req(OP_FREE, 16'h0000, '0, 16'h0000);
    send_req(OP_FREE, 16'd200, '0, 16'h0000);
    send_req(OP_UNUSED, 16'hFFFF, NUM_CNT, 16'hFFFF);
  endtask

  task automatic test_table_limits();
    drain_responses();
    write_usable_count(COUNT_W'(1));
    send_req(OP_NEW, 16'h0000, '0, 16'h0000);
    // nothing left below the limit
    send_req(OP_NEW, 16'h0000, '0, 16'h0000);
    drain_responses();
    write_usable_count(COUNT_W'(16));
    // extend runs out partway and keeps what it linked
    send_req(OP_EXTEND, 16'h0000, NUM_CNT, 16'h0000);
  endtask

  task automatic test_random_traffic();
    int                 pick;
    logic [2:0]         op;
    logic [15:0]        sb;
    logic [15:0]        ev;
    logic [COUNT_W-1:0] amt;
    logic [COUNT_W-1:0] usable;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: usable = USABLE_RST;
        1: usable = COUNT_W'(1);
        2: usable = COUNT_W'(23);
        3: usable = COUNT_W'(300);
        default: usable = NUM_CNT;
      endcase
      drain_responses();
      write_usable_count(usable);
      repeat (23) begin
        pick = $urandom_range(0, 99);
        if (pick < 18) op = OP_NEW;
        else if (pick < 36) op = OP_EXTEND;
        else if (pick < 48) op = OP_FREE;
        else if (pick < 60) op = OP_COUNT;
        else if (pick < 72) op = OP_SKIP;
        else if (pick < 86) op = OP_WRITE;
        else if (pick < 96) op = OP_READ;
        else op = OP_UNUSED;

        // mostly known heads, some empty, free, loose and out of range starts
        pick = $urandom_range(0, 99);
        if (pick < 60 && chain_heads.size() != 0) begin
          sb = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        end else if (pick < 70) begin
          sb = CHAIN_END;
        end else if (pick < 80) begin
          sb = 16'($urandom_range(0, 63));
        end else if (pick < 90) begin
          sb = 16'($urandom_range(0, NUM_BLOCKS - 1));
        end else begin
          sb = 16'($urandom_range(NUM_BLOCKS, 16'hFFFE));
        end

        // long extends only where the scan range is short
        case (op)
          OP_EXTEND: begin
            if (usable_model <= 64 && $urandom_range(0, 1) == 1) begin
              amt = COUNT_W'($urandom_range(0, NUM_BLOCKS));
            end else begin
              amt = COUNT_W'($urandom_range(0, 6));
            end
          end
          OP_SKIP: begin
            if ($urandom_range(0, 3) == 0) amt = COUNT_W'($urandom_range(0, NUM_BLOCKS));
            else amt = COUNT_W'($urandom_range(0, 12));
          end
          default: amt = COUNT_W'($urandom_range(0, NUM_BLOCKS));
        endcase

        // raw values: end marks, links to heads, free, short links, bad links, random values
        case ($urandom_range(0, 5))
          0: ev = CHAIN_END;
          1: begin
            if (chain_heads.size() != 0) begin
              ev = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
            end else begin
              ev = 16'h0000;
            end
          end
          2: ev = 16'h0000;
          3: ev = 16'($urandom_range(0, 63));
          4: ev = 16'($urandom_range(NUM_BLOCKS, 16'hFFFE));
          default: ev = 16'($urandom());
        endcase
        send_req(op, sb, amt, ev);
      end
    end
  endtask

  // receiver: ready runs, short and long stalls, now and then a long clean stretch
  initial begin : rx_pattern
    int run;
    out_ready = 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) run = $urandom_range(100, 300);
      else run = $urandom_range(1, 40);
      repeat (run) begin
        @(posedge clk);
        out_ready <= 1'b1;
      end
      case ($urandom_range(0, 3))
        0: run = 0;
        1, 2: run = $urandom_range(1, 4);
        default: run = $urandom_range(10, 40);
      endcase
      repeat (run) begin
        @(posedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // response checker, oldest prediction first
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (resp_expect_q.size() == 0) begin
        report_mismatch("beat with nothing expected", out_item.result_block, 16'h0000);
      end else begin
        resp_want = resp_expect_q.pop_front();
        if (out_item.result_block !== resp_want.result_block) begin
          report_mismatch("result_block", out_item.result_block, resp_want.result_block);
        end
        if (out_item.result_count !== resp_want.result_count) begin
          report_mismatch("result_count", 16'(out_item.result_count),
                          16'(resp_want.result_count));
        end
        if (out_item.status !== resp_want.status) begin
          report_mismatch("status", 16'(out_item.status), 16'(resp_want.status));
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_item       = '0;
    err_count     = 0;
    tx_burst_left = 1;
    foreach (fat_model[i]) fat_model[i] = 16'h0000;
    usable_model = USABLE_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_new_chains();
    test_extend_chain();
    test_walk_chain();
    test_raw_entries();
    test_broken_chains();
    test_table_limits();
    test_random_traffic();
    drain_responses();

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/fcte_pkg.sv
design/fat_chain_table_engine.sv
verif/fat_chain_table_engine_test.sv
